FILE: design/bbcl_pkg.sv
// shared types and constants for the lru block buffer tag cache
package bbcl_pkg;

  localparam int unsigned DEV_W = 8;
  localparam int unsigned SEC_W = 32;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned OP_W  = 2;

  typedef enum logic [OP_W-1:0] {
    DISK_NONE  = 2'd0,
    DISK_READ  = 2'd1,
    DISK_WRITE = 2'd2
  } disk_op_e;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_WRITE_REQ,
    EMIT_HIT,
    EMIT_WRITEBACK,
    EMIT_FILL
  } emit_e;

  typedef struct packed {
    logic  load;
    logic  lookup;
    logic  select;
    logic  read;
    emit_e emit;
  } cmd_t;

  typedef struct packed {
    logic is_write;
    logic hit;
    logic victim_dirty;
  } status_t;

endpackage

FILE: design/bbcl_dpath.sv
// datapath: request registers, tag store, lru ranks, search and result registers
module bbcl_dpath #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_type_i,
  input  logic [bbcl_pkg::DEV_W-1:0]  dev_i,
  input  logic [bbcl_pkg::SEC_W-1:0]  sector_i,
  input  logic [bbcl_pkg::IDX_W-1:0]  entry_index_i,
  input  bbcl_pkg::cmd_t              cmd_i,
  output bbcl_pkg::status_t           status_o,
  output logic                        result_valid_o,
  output logic [bbcl_pkg::OP_W-1:0]   disk_op_o,
  output logic [bbcl_pkg::DEV_W-1:0]  disk_dev_o,
  output logic [bbcl_pkg::SEC_W-1:0]  disk_sector_o,
  output logic [bbcl_pkg::IDX_W-1:0]  buffer_entry_o,
  output logic                        was_hit_o,
  output logic                        last_o
);
  import bbcl_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam logic [IDX_W:0] ENTRIES_X = ENTRIES[IDX_W:0];
  localparam logic [IW-1:0] TOP_RANK = IW'(ENTRIES - 1);

  // latched request
  logic             req_type_q;
  logic [DEV_W-1:0] req_dev_q;
  logic [SEC_W-1:0] req_sec_q;
  logic [IDX_W-1:0] req_idx_q;

  // tag store and flags
  logic [DEV_W-1:0]   tag_dev_q [ENTRIES];
  logic [SEC_W-1:0]   tag_sec_q [ENTRIES];
  logic [ENTRIES-1:0] present_q;
  logic [ENTRIES-1:0] valid_q;
  logic [ENTRIES-1:0] dirty_q;
  logic [IW-1:0]      rank_q [ENTRIES];

  // search pipeline
  logic [ENTRIES-1:0] hit_vec_d, hit_vec_q;
  logic [ENTRIES-1:0] lru_vec_d, lru_vec_q;
  logic [IW-1:0]      hit_sel, lru_sel;
  logic [IW-1:0]      sel_d, sel_q;
  logic               hit_q;
  logic               in_range_d, in_range_q;

  // entry read at the selected index
  logic [DEV_W-1:0] rd_dev_q;
  logic [SEC_W-1:0] rd_sec_q;
  logic             rd_present_q;
  logic             rd_dirty_q;
  logic             rd_valid_q;
  logic [IW-1:0]    rd_rank_q;

  // result registers
  logic             out_valid_d, out_valid_q;
  disk_op_e         out_op_d, out_op_q;
  logic [DEV_W-1:0] out_dev_d, out_dev_q;
  logic [SEC_W-1:0] out_sec_d, out_sec_q;
  logic [IDX_W-1:0] out_entry_d, out_entry_q;
  logic             out_hit_d, out_hit_q;
  logic             out_last_d, out_last_q;

  logic wr_ok;
  logic do_retag;
  logic do_promote;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_type_q <= req_type_i;
      req_dev_q  <= dev_i;
      req_sec_q  <= sector_i;
      req_idx_q  <= entry_index_i;
    end
  end

  // per-entry compares, independent of each other
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec_d[i] = present_q[i] && (tag_dev_q[i] == req_dev_q) &&
                     (tag_sec_q[i] == req_sec_q);
      lru_vec_d[i] = (rank_q[i] == '0);
    end
  end

  // vectors are one-hot or empty, so an or of indices encodes them
  always_comb begin
    hit_sel = '0;
    lru_sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec_q[i]) hit_sel = hit_sel | IW'(i);
      if (lru_vec_q[i]) lru_sel = lru_sel | IW'(i);
    end
    in_range_d = {1'b0, req_idx_q} < ENTRIES_X;
    if (req_type_q) begin
      sel_d = in_range_d ? req_idx_q[IW-1:0] : '0;
    end else if (|hit_vec_q) begin
      sel_d = hit_sel;
    end else begin
      sel_d = lru_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_vec_q <= hit_vec_d;
      lru_vec_q <= lru_vec_d;
    end
    if (cmd_i.select) begin
      sel_q      <= sel_d;
      hit_q      <= |hit_vec_q;
      in_range_q <= in_range_d;
    end
    if (cmd_i.read) begin
      rd_dev_q     <= tag_dev_q[sel_q];
      rd_sec_q     <= tag_sec_q[sel_q];
      rd_present_q <= present_q[sel_q];
      rd_dirty_q   <= dirty_q[sel_q];
      rd_valid_q   <= valid_q[sel_q];
      rd_rank_q    <= rank_q[sel_q];
    end
  end

  assign status_o.is_write     = req_type_q;
  assign status_o.hit          = hit_q;
  assign status_o.victim_dirty = rd_present_q && rd_dirty_q;

  assign wr_ok      = in_range_q && rd_present_q;
  assign do_retag   = (cmd_i.emit == EMIT_FILL);
  assign do_promote = do_retag || (cmd_i.emit == EMIT_HIT);

  always_comb begin
    out_valid_d = 1'b1;
    out_op_d    = DISK_NONE;
    out_dev_d   = req_dev_q;
    out_sec_d   = req_sec_q;
    out_entry_d = IDX_W'(sel_q);
    out_hit_d   = 1'b0;
    out_last_d  = 1'b1;
    case (cmd_i.emit)
      EMIT_WRITE_REQ: begin
        out_entry_d = req_idx_q;
        if (wr_ok) begin
          out_op_d  = DISK_WRITE;
          out_dev_d = rd_dev_q;
          out_sec_d = rd_sec_q;
        end else begin
          out_dev_d = '0;
          out_sec_d = '0;
        end
      end
      EMIT_HIT: begin
        out_op_d  = rd_valid_q ? DISK_NONE : DISK_READ;
        out_hit_d = 1'b1;
      end
      EMIT_WRITEBACK: begin
        out_op_d   = DISK_WRITE;
        out_dev_d  = rd_dev_q;
        out_sec_d  = rd_sec_q;
        out_last_d = 1'b0;
      end
      EMIT_FILL: begin
        out_op_d = DISK_READ;
      end
      default: begin
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_op_q    <= out_op_d;
    out_dev_q   <= out_dev_d;
    out_sec_q   <= out_sec_d;
    out_entry_q <= out_entry_d;
    out_hit_q   <= out_hit_d;
    out_last_q  <= out_last_d;
  end

  // tags carry no reset: they are only seen behind a present flag
  always_ff @(posedge clk_i) begin
    if (do_retag) begin
      tag_dev_q[sel_q] <= req_dev_q;
      tag_sec_q[sel_q] <= req_sec_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      valid_q   <= '0;
      dirty_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= IW'(i);
      end
    end else begin
      if ((cmd_i.emit == EMIT_WRITE_REQ) && wr_ok) begin
        dirty_q[sel_q] <= 1'b1;
      end
      if (do_promote) begin
        valid_q[sel_q] <= 1'b1;
      end
      if (do_retag) begin
        present_q[sel_q] <= 1'b1;
        dirty_q[sel_q]   <= 1'b0;
      end
      // move the entry to the top, close the gap it leaves
      if (do_promote) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IW'(i) == sel_q) begin
            rank_q[i] <= TOP_RANK;
          end else if (rank_q[i] > rd_rank_q) begin
            rank_q[i] <= rank_q[i] - 1'b1;
          end
        end
      end
    end
  end

  assign result_valid_o = out_valid_q;
  assign disk_op_o      = out_op_q;
  assign disk_dev_o     = out_dev_q;
  assign disk_sector_o  = out_sec_q;
  assign buffer_entry_o = out_entry_q;
  assign was_hit_o      = out_hit_q;
  assign last_o         = out_last_q;

  // ranks stay a permutation, so exactly one entry is least recent
  a_one_lru: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(lru_vec_d))
    else $error("lru rank zero not unique");

  // a tag is never held by two entries
  a_unique_tag: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(hit_vec_d))
    else $error("tag matches more than one entry");

  // a write-back transfer is always followed by the fill transfer
  a_wb_then_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |=> (out_valid_q && out_last_q &&
                                      (out_op_q == DISK_READ)))
    else $error("write-back not followed by fill");

endmodule

FILE: design/bbcl_ctrl.sv
// controller: sequences lookup, select, read and result transfers per request
module bbcl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  bbcl_pkg::status_t status_i,
  output bbcl_pkg::cmd_t    cmd_o,
  output logic              busy_o
);
  import bbcl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SELECT,
    ST_READ,
    ST_EMIT,
    ST_FILL
  } state_e;

  state_e state_q, state_d;
  logic   needs_wb;
  logic   accept;

  assign needs_wb = !status_i.is_write && !status_i.hit && status_i.victim_dirty;

  // a new request may enter while the final result of the last one goes out
  assign busy_o = !((state_q == ST_IDLE) || (state_q == ST_FILL) ||
                    ((state_q == ST_EMIT) && !needs_wb));
  assign accept = start_i && !busy_o;

  always_comb begin
    cmd_o        = '0;
    cmd_o.emit   = EMIT_NONE;
    cmd_o.load   = accept;
    state_d      = accept ? ST_LOOKUP : ST_IDLE;
    case (state_q)
      ST_IDLE: begin
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_SELECT;
      end
      ST_SELECT: begin
        cmd_o.select = 1'b1;
        state_d      = ST_READ;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.is_write) begin
          cmd_o.emit = EMIT_WRITE_REQ;
        end else if (status_i.hit) begin
          cmd_o.emit = EMIT_HIT;
        end else if (needs_wb) begin
          cmd_o.emit = EMIT_WRITEBACK;
          state_d    = ST_FILL;
        end else begin
          cmd_o.emit = EMIT_FILL;
        end
      end
      ST_FILL: begin
        cmd_o.emit = EMIT_FILL;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_LOOKUP))
    else $error("accepted request did not start lookup");

  a_fill_after_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> ($past(state_q) == ST_EMIT))
    else $error("fill state entered out of order");

endmodule

FILE: design/block_buffer_cache_lru.sv
// top level of the fully associative lru block buffer tag cache
// a request passes lookup compare, select encode, entry read and result register in order
// the first result strobe is registered from the emit state, after the lookup, select and
// read states; a miss on a dirty victim gives a second result, the fill, in the next cycle
// the next request is taken at the edge that registers the final result of the last one
// reset clears all present, valid and dirty flags and sets each rank to its entry index
// results cannot be stalled: each one is shown for exactly one cycle
module block_buffer_cache_lru #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        req_type_i,
  input  logic [bbcl_pkg::DEV_W-1:0]  dev_i,
  input  logic [bbcl_pkg::SEC_W-1:0]  sector_i,
  input  logic [bbcl_pkg::IDX_W-1:0]  entry_index_i,
  output logic                        result_valid_o,
  output logic [bbcl_pkg::OP_W-1:0]   disk_op_o,
  output logic [bbcl_pkg::DEV_W-1:0]  disk_dev_o,
  output logic [bbcl_pkg::SEC_W-1:0]  disk_sector_o,
  output logic [bbcl_pkg::IDX_W-1:0]  buffer_entry_o,
  output logic                        was_hit_o,
  output logic                        last_o
);
  import bbcl_pkg::*;

  cmd_t    cmd;
  status_t status;

  bbcl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  bbcl_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_type_i     (req_type_i),
    .dev_i          (dev_i),
    .sector_i       (sector_i),
    .entry_index_i  (entry_index_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .disk_op_o      (disk_op_o),
    .disk_dev_o     (disk_dev_o),
    .disk_sector_o  (disk_sector_o),
    .buffer_entry_o (buffer_entry_o),
    .was_hit_o      (was_hit_o),
    .last_o         (last_o)
  );

endmodule
